// ===== rtl/u8u2_pkg.sv =====
package u8u2_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int PEND_W = 3;

  localparam logic [UNIT_W-1:0] UNIT_LIMIT_RESET = 16'hFFFF;

  localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD5_MASK  = 8'hFC;
  localparam logic [BYTE_W-1:0] LEAD5_CODE  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD6_MASK  = 8'hFE;
  localparam logic [BYTE_W-1:0] LEAD6_CODE  = 8'hFC;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD2_DATA  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_DATA  = 8'h0F;

  localparam logic [PEND_W-1:0] PEND_NONE = 3'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 3'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 3'd2;
  localparam logic [PEND_W-1:0] PEND_3    = 3'd3;
  localparam logic [PEND_W-1:0] PEND_4    = 3'd4;
  localparam logic [PEND_W-1:0] PEND_5    = 3'd5;

endpackage

// ===== rtl/utf8_to_ucs2_decoder_top.sv =====
// UTF-8 to UCS-2 decoder.
// Input channel: in_valid/in_ready carry one string byte (data_byte) and a
// flag marking the final byte of the string (last_byte).
// Output channel: out_valid/out_ready carry one result: code_unit with
// unit_valid when a one-, two- or three-byte sequence completes, and on the
// final byte end_of_string with the truncated and limit_hit flags.
// Bytes that complete no unit and are not final produce no transaction.
// cfg_wr_en/cfg_wr_data write unit_limit, the largest number of units sent
// per string; write it only while the block is idle.
// A byte passes through the input register, then the result register.
// Throughput: one byte per cycle while no result-bearing byte waits on a
// stalled output; the state update lies between the two registers.
// Reset clears both valid bits and the sequence state and sets unit_limit to
// 65535. When the receiver stalls, the held result stays on the output and
// one more byte is taken into the input register; bytes that produce no
// result keep flowing past the stalled result.
module utf8_to_ucs2_decoder_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [u8u2_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [u8u2_pkg::UNIT_W-1:0] code_unit,
  output logic                        unit_valid,
  output logic                        end_of_string,
  output logic                        truncated,
  output logic                        limit_hit,
  input  logic                        cfg_wr_en,
  input  logic [u8u2_pkg::UNIT_W-1:0] cfg_wr_data
);
  import u8u2_pkg::*;

  logic [UNIT_W-1:0] unit_limit;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_go;

  logic [PEND_W-1:0] bytes_pending, bytes_pending_next;
  logic              skipping, skipping_next;
  logic [UNIT_W-1:0] partial_value, partial_value_next;
  logic [UNIT_W-1:0] units_emitted, units_emitted_next;
  logic              limit_seen, limit_seen_next;

  logic              done;
  logic              emit;
  logic [UNIT_W-1:0] unit;
  logic [UNIT_W-1:0] shifted;
  logic              has_result;

  assign shifted    = {partial_value[UNIT_W-7:0], s1_byte[5:0]};
  assign has_result = emit || s1_last;
  assign s1_go      = s1_valid && (!has_result || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_go;

  always_comb begin
    bytes_pending_next = bytes_pending;
    skipping_next      = skipping;
    partial_value_next = partial_value;
    units_emitted_next = units_emitted;
    limit_seen_next    = limit_seen;
    done               = 1'b0;
    emit               = 1'b0;
    unit               = '0;
    if (bytes_pending != PEND_NONE) begin
      if (!skipping) begin
        partial_value_next = shifted;
      end
      bytes_pending_next = bytes_pending - PEND_ONE;
      if (bytes_pending_next == PEND_NONE) begin
        if (!skipping) begin
          done = 1'b1;
          unit = shifted;
        end
        skipping_next      = 1'b0;
        partial_value_next = '0;
      end
    end else if ((s1_byte & ASCII_MASK) == '0) begin
      done = 1'b1;
      unit = {{(UNIT_W-BYTE_W){1'b0}}, s1_byte};
    end else if ((s1_byte & LEAD2_MASK) == LEAD2_CODE) begin
      partial_value_next = {{(UNIT_W-BYTE_W){1'b0}}, s1_byte & LEAD2_DATA};
      bytes_pending_next = PEND_ONE;
    end else if ((s1_byte & LEAD3_MASK) == LEAD3_CODE) begin
      partial_value_next = {{(UNIT_W-BYTE_W){1'b0}}, s1_byte & LEAD3_DATA};
      bytes_pending_next = PEND_TWO;
    end else if ((s1_byte & LEAD4_MASK) == LEAD4_CODE) begin
      skipping_next      = 1'b1;
      bytes_pending_next = PEND_3;
    end else if ((s1_byte & LEAD5_MASK) == LEAD5_CODE) begin
      skipping_next      = 1'b1;
      bytes_pending_next = PEND_4;
    end else if ((s1_byte & LEAD6_MASK) == LEAD6_CODE) begin
      skipping_next      = 1'b1;
      bytes_pending_next = PEND_5;
    end
    if (done) begin
      if (units_emitted < unit_limit) begin
        emit               = 1'b1;
        units_emitted_next = units_emitted + UNIT_W'(1);
      end else begin
        limit_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_limit <= UNIT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unit_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_NONE;
      skipping      <= 1'b0;
      partial_value <= '0;
      units_emitted <= '0;
      limit_seen    <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        bytes_pending <= PEND_NONE;
        skipping      <= 1'b0;
        partial_value <= '0;
        units_emitted <= '0;
        limit_seen    <= 1'b0;
      end else begin
        bytes_pending <= bytes_pending_next;
        skipping      <= skipping_next;
        partial_value <= partial_value_next;
        units_emitted <= units_emitted_next;
        limit_seen    <= limit_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      code_unit     <= emit ? unit : '0;
      unit_valid    <= emit;
      end_of_string <= s1_last;
      truncated     <= s1_last && (bytes_pending_next != PEND_NONE);
      limit_hit     <= s1_last && limit_seen_next;
    end
  end

endmodule

// ===== rtl/u8u2_checker.sv =====
module u8u2_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [u8u2_pkg::UNIT_W-1:0] code_unit,
  input logic                        unit_valid,
  input logic                        end_of_string,
  input logic                        truncated,
  input logic                        limit_hit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(end_of_string))
    else $error("stalled output transaction changed");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_valid |-> end_of_string)
    else $error("transaction without a unit that does not end the string");

  a_flags_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_string |-> !truncated && !limit_hit)
    else $error("end flags set on a transaction inside a string");

  a_empty_unit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_valid |-> code_unit == '0)
    else $error("code unit not zero without a completed character");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_to_ucs2_decoder_top u8u2_checker u_u8u2_checker (.*);
